// ----- rtl/core/fmcq_pkg.sv -----
`default_nettype none

package fmcq_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CH_N       = 3;
  localparam int unsigned TDATA_W    = PIX_W * CH_N;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned STEP_W     = $clog2(SUM_W);
  localparam int unsigned DIM_CFG_W  = 13;
  localparam int unsigned IVL_W      = 8;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned MAX_DIMENSION_DEF = 4096;

  localparam logic [DIM_CFG_W-1:0] WIDTH_RST    = 13'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [IVL_W-1:0]     INTERVAL_RST = 8'd1;

  localparam logic [PIX_W-1:0] LOW_CUT  = 8'd85;
  localparam logic [PIX_W-1:0] HIGH_CUT = 8'd170;
  localparam logic [PIX_W-1:0] FULL     = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_INTERVAL = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic cfg_we;
    logic pix_take;
    logic div_start;
    logic div_step;
    logic reduce;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_ge;
    logic measured;
  } dp_sts_t;

  function automatic logic [PIX_W-1:0] map_level(input logic [PIX_W-1:0] x);
    logic [PIX_W-1:0] r;
    if (x < LOW_CUT) begin
      r = '0;
    end else if (x > HIGH_CUT) begin
      r = FULL;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fmcq_dp.sv -----
`default_nettype none

module fmcq_dp #(
  parameter int unsigned MAX_DIMENSION = fmcq_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire fmcq_pkg::dp_cmd_t                 cmd_i,
  output fmcq_pkg::dp_sts_t                      sts_o,
  input  wire logic [fmcq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fmcq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [fmcq_pkg::TDATA_W-1:0]      pix_i,
  input  wire logic                              pix_last_i,
  output logic      [fmcq_pkg::TDATA_W-1:0]      mean_o
);
  import fmcq_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned DIV_W = 2 * DIM_W;

  logic [DIM_CFG_W-1:0] width_q, height_q;
  logic [IVL_W-1:0]     interval_q;
  logic [IVL_W-1:0]     ivl_eff;
  logic [DIM_W-1:0]     width_cl, height_cl;
  logic [DIV_W-1:0]     div_q;

  logic [IVL_W-1:0]     phase_q;
  logic                 meas_q;
  logic [IVL_W:0]       phase_inc;
  logic                 phase_wrap;

  logic [SUM_W-1:0]     sum_q   [CH_N];
  logic [SUM_W-1:0]     sum_sat [CH_N];
  logic [SUM_W:0]       sum_wide[CH_N];

  logic [SUM_W-1:0]     num_q   [CH_N];
  logic [DIV_W-1:0]     rem_q   [CH_N];
  logic [DIV_W:0]       rem_sh  [CH_N];
  logic                 rem_ge  [CH_N];
  logic [DIV_W:0]       rem_sub [CH_N];

  logic [PIX_W-1:0]     mean_q  [CH_N];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      interval_q <= INTERVAL_RST;
    end else if (cmd_i.cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WIDTH:    width_q    <= cfg_data_i[DIM_CFG_W-1:0];
        REG_HEIGHT:   height_q   <= cfg_data_i[DIM_CFG_W-1:0];
        REG_INTERVAL: interval_q <= cfg_data_i[IVL_W-1:0];
        default:      ;
      endcase
    end
  end

  assign ivl_eff = (interval_q == '0) ? IVL_W'(1) : interval_q;

  always_comb begin
    if (width_q == '0) begin
      width_cl = DIM_W'(1);
    end else if (32'(width_q) > 32'(MAX_DIMENSION)) begin
      width_cl = DIM_W'(MAX_DIMENSION);
    end else begin
      width_cl = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      height_cl = DIM_W'(1);
    end else if (32'(height_q) > 32'(MAX_DIMENSION)) begin
      height_cl = DIM_W'(MAX_DIMENSION);
    end else begin
      height_cl = DIM_W'(height_q);
    end
  end

  // divisor is registered from the clamped width and height config registers
  always_ff @(posedge clk_i) begin
    div_q <= DIV_W'(width_cl) * DIV_W'(height_cl);
  end

  // frame phase
  assign phase_inc  = {1'b0, phase_q} + (IVL_W+1)'(1);
  assign phase_wrap = (phase_inc == {1'b0, ivl_eff});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      meas_q  <= 1'b1;
    end else if (cmd_i.pix_take && pix_last_i) begin
      phase_q <= phase_wrap ? '0 : phase_inc[IVL_W-1:0];
      meas_q  <= phase_wrap;
    end else if (cmd_i.reduce) begin
      phase_q <= phase_q - ivl_eff;
    end
  end

  assign sts_o.phase_ge = (phase_q >= ivl_eff);
  assign sts_o.measured = meas_q;

  // per-channel accumulate and divide lanes
  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      sum_wide[ch] = {1'b0, sum_q[ch]} + (SUM_W+1)'(map_level(pix_i[ch*PIX_W +: PIX_W]));
      sum_sat[ch]  = sum_wide[ch][SUM_W] ? '1 : sum_wide[ch][SUM_W-1:0];
      rem_sh[ch]   = {rem_q[ch], num_q[ch][SUM_W-1]};
      rem_ge[ch]   = (rem_sh[ch] >= {1'b0, div_q});
      rem_sub[ch]  = rem_sh[ch] - {1'b0, div_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        sum_q[ch] <= '0;
      end
    end else if (cmd_i.pix_take && meas_q) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        sum_q[ch] <= pix_last_i ? '0 : sum_sat[ch];
      end
    end
  end

  // restoring division, one quotient bit per step; quotient replaces the numerator
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < CH_N; ch++) begin
      if (cmd_i.div_start) begin
        num_q[ch] <= sum_sat[ch];
        rem_q[ch] <= '0;
      end else if (cmd_i.div_step) begin
        num_q[ch] <= {num_q[ch][SUM_W-2:0], rem_ge[ch]};
        rem_q[ch] <= rem_ge[ch] ? rem_sub[ch][DIV_W-1:0] : rem_sh[ch][DIV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int ch = 0; ch < CH_N; ch++) begin
        mean_q[ch] <= (|num_q[ch][SUM_W-1:PIX_W]) ? FULL : num_q[ch][PIX_W-1:0];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      mean_o[ch*PIX_W +: PIX_W] = mean_q[ch];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/fmcq_ctrl.sv -----
`default_nettype none

module fmcq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire logic              s_tlast_i,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire fmcq_pkg::dp_sts_t sts_i,
  output fmcq_pkg::dp_cmd_t      cmd_o
);
  import fmcq_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCUM  = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e            state_d, state_q;
  logic [STEP_W-1:0] step_d, step_q;
  logic              out_valid_d, out_valid_q;
  logic              take, out_free, step_last;

  assign s_tready_o  = (state_q == ST_ACCUM) && !sts_i.phase_ge;
  assign cfg_ready_o = (state_q == ST_ACCUM);
  assign m_tvalid_o  = out_valid_q;

  assign take      = s_tvalid_i && s_tready_o;
  assign out_free  = !out_valid_q || m_tready_i;
  assign step_last = (step_q == STEP_W'(SUM_W - 1));

  always_comb begin
    cmd_o.cfg_we    = cfg_valid_i && cfg_ready_o;
    cmd_o.pix_take  = take;
    cmd_o.div_start = take && s_tlast_i && sts_i.measured;
    cmd_o.div_step  = (state_q == ST_DIVIDE);
    cmd_o.reduce    = (state_q == ST_REDUCE) && sts_i.phase_ge;
    cmd_o.out_load  = (state_q == ST_DONE) && out_free;
  end

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      ST_ACCUM: begin
        if (sts_i.phase_ge) begin
          state_d = ST_REDUCE;
        end else if (cmd_o.div_start) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_REDUCE: begin
        if (!sts_i.phase_ge) begin
          state_d = ST_ACCUM;
        end
      end
      ST_DIVIDE: begin
        step_d = step_q + STEP_W'(1);
        if (step_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stream stalls right after a measured end of frame
  a_stall_after_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !s_tready_o)
    else $error("input accepted while a division starts");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(state_q == ST_DONE))
    else $error("result shown without a finished division");

  a_divide_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && step_last) |=> (state_q == ST_DONE))
    else $error("division did not end after the last step");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (m_tvalid_o && state_q == ST_ACCUM))
    else $error("output load lost");

endmodule

`default_nettype wire

// ----- rtl/core/frame_mean_color_quantized_unit.sv -----
// Pixels are taken at one per cycle while a frame streams in; a measured end-of-frame pixel
// stalls the input through 32 steps of the per-channel restoring dividers (one quotient bit
// per step) and one output load, longer while an earlier result waits for m_axis_tready.
// The result beat appears once the output load has registered the means after the last step.
// Lowering frame_interval to or below the current phase stalls the input for phase reduction.
// Reset (async, active low): 640 x 480, interval 1, sums and phase cleared, no result pending.
`default_nettype none

module frame_mean_color_quantized_unit #(
  parameter int unsigned MAX_DIMENSION = fmcq_pkg::MAX_DIMENSION_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [fmcq_pkg::TDATA_W-1:0]    s_axis_tdata,  // red, green, blue
  input  wire logic                            s_axis_tlast,  // end_of_frame
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [fmcq_pkg::TDATA_W-1:0]    m_axis_tdata,  // mean_red, mean_green, mean_blue
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fmcq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fmcq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fmcq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fmcq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmcq_dp #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (s_axis_tdata),
    .pix_last_i  (s_axis_tlast),
    .mean_o      (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_frame_mean_color_quantized_unit.sv -----
`timescale 1ns / 100ps

module tb_frame_mean_color_quantized_unit;
  import fmcq_pkg::*;

  localparam int unsigned DARK_EDGE    = 85;
  localparam int unsigned BRIGHT_EDGE  = 170;
  localparam int unsigned CH_MAX       = 255;
  localparam int unsigned DIM_LIMIT    = 4096;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RAND_PIXELS  = 400;
  localparam int unsigned RAND_MEANS   = 40;

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } mean_t;

  typedef struct {
    row_kind_e  kind;
    cfg_reg_e   sel;
    logic [12:0] value;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       eof;
    logic       known;
    mean_t      known_mean;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;   // red, green, blue
  logic                  s_axis_tlast;   // end_of_frame
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;   // mean_red, mean_green, mean_blue
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  frame_mean_color_quantized_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state: configuration, interval phase and channel sums
  logic [12:0] cur_width;
  logic [12:0] cur_height;
  logic [7:0]  cur_interval;
  logic [7:0]  phase_cnt;
  logic [31:0] acc_red;
  logic [31:0] acc_green;
  logic [31:0] acc_blue;

  mean_t       mean_queue[$];
  stim_row_t   dir_rows[$];

  int unsigned err_count;
  int unsigned pixels_sent;
  int unsigned means_pushed;
  int unsigned means_checked;
  int unsigned cfg_writes;
  int unsigned cycle_count;
  int          burst_left;
  logic        hold_req;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("frame_mean_color_quantized_unit verification failed");
      $finish;
    end
  end

  function automatic logic [7:0] quantize(input logic [7:0] x);
    if (x < DARK_EDGE) return 8'd0;
    if (x > BRIGHT_EDGE) return CH_MAX[7:0];
    return x;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [7:0] v);
    logic [32:0] t;
    t = {1'b0, s} + {25'd0, v};
    return t[32] ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [12:0] clamp_dim(input logic [12:0] d);
    if (d == 13'd0) return 13'd1;
    if (d > DIM_LIMIT) return DIM_LIMIT[12:0];
    return d;
  endfunction

  function automatic logic [7:0] mean_of(input logic [31:0] s, input logic [25:0] div);
    logic [31:0] q;
    q = s / {6'd0, div};
    return (q > CH_MAX) ? CH_MAX[7:0] : q[7:0];
  endfunction

  // Fold one accepted pixel into the sums; report the frame means on a measured end of frame
  task automatic accumulate_pixel(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic eof,
                                  output logic emits, output mean_t m);
    logic [25:0] divisor;
    int          step_phase;
    int          eff;
    emits = 1'b0;
    m = '0;
    if (phase_cnt == 8'd0) begin
      acc_red   = sat_add(acc_red, quantize(r));
      acc_green = sat_add(acc_green, quantize(g));
      acc_blue  = sat_add(acc_blue, quantize(b));
      if (eof) begin
        divisor = clamp_dim(cur_width) * clamp_dim(cur_height);
        m.red   = mean_of(acc_red, divisor);
        m.green = mean_of(acc_green, divisor);
        m.blue  = mean_of(acc_blue, divisor);
        acc_red   = '0;
        acc_green = '0;
        acc_blue  = '0;
        emits = 1'b1;
      end
    end
    if (eof) begin
      eff = (cur_interval == 8'd0) ? 1 : int'(cur_interval);
      step_phase = (int'(phase_cnt) + 1) % eff;
      phase_cnt = step_phase[7:0];
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic eof, input logic known, input mean_t known_mean);
    logic  emits;
    mean_t m;
    int    gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    s_axis_tlast  <= eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
    accumulate_pixel(r, g, b, eof, emits, m);
    if (emits) begin
      mean_queue.insert(mean_queue.size(), known ? known_mean : m);
      means_pushed++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drain all results, then let any phase reduction or divide finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [12:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (sel)
      REG_WIDTH:    cur_width = value;
      REG_HEIGHT:   cur_height = value;
      REG_INTERVAL: cur_interval = value[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic stim_row_t cfg_row(input cfg_reg_e sel, input logic [12:0] value);
    stim_row_t row;
    row = '{kind: ROW_CONFIG, sel: sel, value: value, r: 8'd0, g: 8'd0, b: 8'd0,
            eof: 1'b0, known: 1'b0, known_mean: '0};
    return row;
  endfunction

  function automatic stim_row_t pix_row(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic eof,
                                        input logic known, input mean_t known_mean);
    stim_row_t row;
    row = '{kind: ROW_PIXEL, sel: REG_WIDTH, value: 13'd0, r: r, g: g, b: b,
            eof: eof, known: known, known_mean: known_mean};
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input stim_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Favor the quantizer thresholds and the channel extremes
  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 2) != 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd84;
      2: return 8'd85;
      3: return 8'd86;
      4: return 8'd169;
      5: return 8'd170;
      6: return 8'd171;
      default: return 8'd255;
    endcase
  endfunction

  always @(posedge clk_i) begin : result_check
    mean_t got;
    mean_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (mean_queue.size() == 0) begin
        $error("unexpected result beat: %0d %0d %0d", got.red, got.green, got.blue);
        err_count++;
      end else begin
        want = mean_queue.pop_front();
        means_checked++;
        if (got.red !== want.red) begin
          $error("mean_red: expected %0d, actual %0d", want.red, got.red);
          err_count++;
        end
        if (got.green !== want.green) begin
          $error("mean_green: expected %0d, actual %0d", want.green, got.green);
          err_count++;
        end
        if (got.blue !== want.blue) begin
          $error("mean_blue: expected %0d, actual %0d", want.blue, got.blue);
          err_count++;
        end
      end
    end
  end

  // Result side: a long hold-off once, then windows of varying readiness
  initial begin : result_sink
    int mode;
    int span;
    int k;
    logic hold_done;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 64);
      for (k = 0; k < span; k++) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((k % 16) > 11);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int    p;
    int    phase_pixels;
    int    rand_pixels;
    int    rand_means_start;
    int    frame_len;
    int    n;
    int    i;
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] ivl;
    mean_t none;

    none = '0;
    err_count = 0;
    pixels_sent = 0;
    means_pushed = 0;
    means_checked = 0;
    cfg_writes = 0;
    cycle_count = 0;
    burst_left = 1;
    hold_req = 1'b0;
    cur_width = WIDTH_RST;
    cur_height = HEIGHT_RST;
    cur_interval = INTERVAL_RST;
    phase_cnt = '0;
    acc_red = '0;
    acc_green = '0;
    acc_blue = '0;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_WIDTH;
    cfg_data_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-pixel frames on a 1x1 divisor show the quantizer directly
    add_row(cfg_row(REG_WIDTH, 13'd1));
    add_row(cfg_row(REG_HEIGHT, 13'd1));
    add_row(pix_row(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0}));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
                    '{8'd255, 8'd255, 8'd255}));
    add_row(pix_row(8'd84, 8'd85, 8'd170, 1'b1, 1'b1,
                    '{8'd170, 8'd85, 8'd0}));
    add_row(pix_row(8'd171, 8'd169, 8'd86, 1'b1, 1'b1,
                    '{8'd86, 8'd169, 8'd255}));
    // More pixels than width * height: means clip at full scale
    add_row(pix_row(8'd255, 8'd200, 8'd100, 1'b0, 1'b0, none));
    add_row(pix_row(8'd255, 8'd200, 8'd100, 1'b1, 1'b1,
                    '{8'd200, 8'd255, 8'd255}));
    add_row(cfg_row(REG_WIDTH, 13'd2));
    add_row(pix_row(8'd100, 8'd0, 8'd255, 1'b0, 1'b0, none));
    add_row(pix_row(8'd101, 8'd255, 8'd0, 1'b1, 1'b0, none));
    // Zero dimensions count as one
    add_row(cfg_row(REG_WIDTH, 13'd0));
    add_row(cfg_row(REG_HEIGHT, 13'd0));
    add_row(pix_row(8'd200, 8'd100, 8'd50, 1'b1, 1'b1,
                    '{8'd0, 8'd100, 8'd255}));
    add_row(cfg_row(REG_WIDTH, 13'd4096));
    add_row(cfg_row(REG_HEIGHT, 13'd4096));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0}));
    // Dimensions beyond the maximum clip to it
    add_row(cfg_row(REG_WIDTH, 13'h1FFF));
    add_row(cfg_row(REG_HEIGHT, 13'h1FFF));
    add_row(pix_row(8'd255, 8'd170, 8'd85, 1'b1, 1'b0, none));
    // Interval of three: measured, skipped, skipped, measured, skipped
    add_row(cfg_row(REG_WIDTH, 13'd1));
    add_row(cfg_row(REG_HEIGHT, 13'd1));
    add_row(cfg_row(REG_INTERVAL, 13'd3));
    add_row(pix_row(8'd90, 8'd90, 8'd90, 1'b1, 1'b0, none));
    add_row(pix_row(8'd255, 8'd255, 8'd255, 1'b1, 1'b0, none));
    add_row(pix_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, none));
    add_row(pix_row(8'd0, 8'd0, 8'd0, 1'b1, 1'b0, none));
    add_row(pix_row(8'd120, 8'd130, 8'd140, 1'b1, 1'b0, none));
    add_row(pix_row(8'd255, 8'd0, 8'd255, 1'b1, 1'b0, none));
    // Interval zero with the phase left above it
    add_row(cfg_row(REG_INTERVAL, 13'd0));
    add_row(pix_row(8'd50, 8'd60, 8'd70, 1'b1, 1'b0, none));
    add_row(pix_row(8'd130, 8'd140, 8'd150, 1'b1, 1'b0, none));
    add_row(cfg_row(REG_INTERVAL, 13'd255));
    add_row(pix_row(8'd200, 8'd200, 8'd200, 1'b1, 1'b0, none));
    add_row(pix_row(8'd1, 8'd1, 8'd1, 1'b1, 1'b0, none));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG) begin
        write_reg(dir_rows[i].sel, dir_rows[i].value);
      end else begin
        send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].eof,
                   dir_rows[i].known, dir_rows[i].known_mean);
      end
    end

    rand_pixels = 0;
    rand_means_start = means_pushed;
    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          w = 13'($urandom_range(1, 4));
          h = 13'($urandom_range(1, 4));
          ivl = 13'd1;
        end
        1: begin
          w = 13'($urandom_range(1, 8));
          h = 13'($urandom_range(1, 2));
          ivl = 13'($urandom_range(2, 4));
        end
        2: begin
          w = 13'($urandom_range(2000, 8191));
          h = 13'($urandom_range(0, 2));
          ivl = 13'd1;
        end
        3: begin
          w = 13'($urandom_range(0, 3));
          h = 13'($urandom_range(0, 3));
          ivl = ($urandom_range(0, 1) != 0) ? 13'd0 : 13'd5;
        end
        default: begin
          w = 13'($urandom_range(1, 6));
          h = 13'($urandom_range(1, 4));
          ivl = 13'($urandom_range(1, 2));
        end
      endcase
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_INTERVAL, ivl);
      if (p == 0) hold_req = 1'b1;
      phase_pixels = 0;
      while ((p < 4 && phase_pixels < RAND_PIXELS / 5) ||
             (p == 4 && rand_pixels < 2000 &&
              (rand_pixels < RAND_PIXELS || means_pushed - rand_means_start < RAND_MEANS)))
      begin
        n = int'(clamp_dim(w)) * int'(clamp_dim(h));
        if ($urandom_range(0, 1) != 0 && n <= 48) frame_len = n;
        else if ($urandom_range(0, 9) == 0) frame_len = $urandom_range(30, 60);
        else frame_len = $urandom_range(1, 24);
        for (i = 0; i < frame_len; i++) begin
          send_pixel(pick_level(), pick_level(), pick_level(), i == frame_len - 1,
                     1'b0, none);
        end
        phase_pixels += frame_len;
        rand_pixels += frame_len;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d pixel beats over 5 random settings plus directed frames,",
             pixels_sent);
    $display("%0d frame means compared and %0d register writes.", means_checked, cfg_writes);
    if (err_count == 0 && mean_queue.size() == 0) begin
      $display("frame_mean_color_quantized_unit verification clean");
    end else begin
      $display("frame_mean_color_quantized_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/fmcq_pkg.sv
rtl/core/fmcq_dp.sv
rtl/core/fmcq_ctrl.sv
rtl/core/frame_mean_color_quantized_unit.sv
tb/sv/tb_frame_mean_color_quantized_unit.sv
